@@ hw/rtl/keyframe_redundancy_filter_macros.svh @@
// assertion macros shared by the keyframe filter rtl
// no dependencies; taken in by `include where a module asserts
`ifndef KEYFRAME_REDUNDANCY_FILTER_MACROS_SVH
`define KEYFRAME_REDUNDANCY_FILTER_MACROS_SVH

// property must hold at every clock edge outside reset
`define KRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// condition implies consequence in the same cycle
`define KRF_ASSERT_IMPL(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/krf_pkg.sv @@
// types, codes and constants of the keyframe redundancy filter
// no dependencies; used by every module of the block
package krf_pkg;

  localparam int unsigned BOUNDARY_DEPTH = 32;
  localparam int unsigned FRAME_ELEMENTS = 12;
  localparam int unsigned MAX_RESULTS    = 2;
  localparam int unsigned RES_FIFO_DEPTH = 4;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 31;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_ELEM  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_FORCE_LINEAR = 2'd1,
    CFG_INTERPOLATED = 2'd2,
    CFG_COMP_COUNT   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] frame_key;
    logic signed [31:0] sample_value;
    logic               end_of_frame;
    logic               end_of_set;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] decided_key;
    logic               keep;
    logic               run_last;
  } out_res_t;

  // boundary table operations for one accepted request
  typedef struct packed {
    logic clear;
    logic add;
    logic first;
  } bt_op_t;

endpackage

@@ hw/rtl/krf_boundary_table.sv @@
// boundary key table with parallel lookup and a running match flag
// depends on krf_pkg and the macro header
`include "keyframe_redundancy_filter_macros.svh"

module krf_boundary_table #(
  parameter int unsigned BOUNDARY_DEPTH = krf_pkg::BOUNDARY_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krf_pkg::bt_op_t    op_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] frame_key_i,
  output logic               match_o
);

  localparam int unsigned CW = $clog2(BOUNDARY_DEPTH + 1);

  logic signed [31:0] bk_q [BOUNDARY_DEPTH];
  logic [CW-1:0]      count_q, count_d;
  logic               match_q, match_d;
  logic               hit;
  logic               room;

  assign room = count_q < CW'(BOUNDARY_DEPTH);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < BOUNDARY_DEPTH; i++) begin
      if ((CW'(i) < count_q) && (bk_q[i] == key_i)) hit = 1'b1;
    end
  end

  // match flag for the key of the open frame is latched on its first element
  assign match_o = op_i.first ? hit : match_q;

  always_comb begin
    count_d = count_q;
    match_d = match_q;
    if (op_i.clear) begin
      count_d = '0;
      match_d = 1'b0;
    end else if (op_i.add && room) begin
      count_d = count_q + CW'(1);
      if (key_i == frame_key_i) match_d = 1'b1;
    end else if (op_i.first) begin
      match_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      match_q <= 1'b0;
    end else begin
      count_q <= count_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BOUNDARY_DEPTH; i++) begin
      if (op_i.add && room && (count_q == CW'(i))) bk_q[i] <= key_i;
    end
  end

  `KRF_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(BOUNDARY_DEPTH), "table overfilled")

endmodule

@@ hw/rtl/krf_frame_mem.sv @@
// two-bank frame element memory, one write and one registered read port
// depends on krf_pkg only for the default of FRAME_ELEMENTS
module krf_frame_mem #(
  parameter int unsigned FRAME_ELEMENTS = krf_pkg::FRAME_ELEMENTS,
  localparam int unsigned DEPTH = 2 * FRAME_ELEMENTS,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/krf_result_fifo.sv @@
// result queue: takes up to two results a cycle, hands out one while out_stall_i is low
// depends on krf_pkg and the macro header
`include "keyframe_redundancy_filter_macros.svh"

module krf_result_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  push_cnt_i,
  input  krf_pkg::out_res_t [1:0]     push_res_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output krf_pkg::out_res_t           out_res_o,
  output logic [$clog2(krf_pkg::RES_FIFO_DEPTH+1)-1:0] count_o
);

  localparam int unsigned D  = krf_pkg::RES_FIFO_DEPTH;
  localparam int unsigned PW = $clog2(D);
  localparam int unsigned CW = $clog2(D + 1);

  krf_pkg::out_res_t buf_q [D];
  logic [PW-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_1;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign wr_ptr_1    = wr_ptr_q + PW'(1);
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = buf_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      wr_ptr_q <= wr_ptr_q + PW'(push_cnt_i);
      cnt_q    <= cnt_q + CW'(push_cnt_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) buf_q[wr_ptr_q] <= push_res_i[0];
    if (push_cnt_i == 2'd2) buf_q[wr_ptr_1] <= push_res_i[1];
  end

  `KRF_ASSERT(a_no_overflow, clk_i, rst_ni, (cnt_q + CW'(push_cnt_i)) <= CW'(D + 1) && (cnt_q + CW'(push_cnt_i) - CW'(pop)) <= CW'(D), "result queue overflow")
  `KRF_ASSERT_IMPL(a_push_range, clk_i, rst_ni, push_cnt_i != 2'd0, push_cnt_i != 2'd3, "bad push count")

endmodule

@@ hw/rtl/keyframe_redundancy_filter.sv @@
// keyframe redundancy filter top level
// depends on krf_pkg, krf_boundary_table, krf_frame_mem, krf_result_fifo
//
// usage: requests enter on in_valid_i / in_stall_o / in_req_i; func selects
// clear boundary table, add boundary key, or one frame element. results leave
// on out_valid_o / out_stall_i / out_res_o, one result per cycle while out_stall_i is low.
// a frame is decided when the next frame completes. a request that ends a frame
// gives one result, none for a first frame not ending the set, two for a later
// frame ending the set (the last frame is then reported kept); run_last marks the last of them.
// throughput: one request per cycle while in_stall_o is low. each stored
// element writes its bank of the frame memory and reads the other bank in the
// same cycle; the compare runs in the next cycle on the registered read data.
// a result enters the output queue in the cycle after the request that caused it
// is taken; it is offered on out_valid_o from the following cycle once older results have left.
// stall: in_stall_o rises when the 4-entry result queue could not take the
// results of the next request; a set of one-element frames thus runs at one
// request per cycle as long as the receiver keeps up.
// reset: clears config to threshold 0, linear mode off, one component, and
// empties the boundary table, the frame state and the result queue; the
// block is ready right after reset. config writes are taken any cycle.
`include "keyframe_redundancy_filter_macros.svh"

module keyframe_redundancy_filter #(
  parameter int unsigned BOUNDARY_DEPTH = krf_pkg::BOUNDARY_DEPTH,
  parameter int unsigned FRAME_ELEMENTS = krf_pkg::FRAME_ELEMENTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [krf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [krf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  krf_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output krf_pkg::out_res_t               out_res_o
);

  localparam int unsigned PW = $clog2(FRAME_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(2 * FRAME_ELEMENTS);
  localparam int unsigned FCW = $clog2(krf_pkg::RES_FIFO_DEPTH + 1);

  typedef struct packed {
    logic               cmp;
    logic               first;
    logic               eof;
    logic               eos;
    logic               bnd;
    logic signed [31:0] key;
    logic signed [31:0] val;
  } s1_tok_t;

  // config
  logic [30:0] thr_q;
  logic        lin_q, interp_q;
  logic [2:0]  cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      lin_q    <= 1'b0;
      interp_q <= 1'b0;
      cc_q     <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (krf_pkg::cfg_reg_e'(cfg_index_i))
        krf_pkg::CFG_THRESHOLD:    thr_q    <= cfg_wdata_i[30:0];
        krf_pkg::CFG_FORCE_LINEAR: lin_q    <= cfg_wdata_i[0];
        krf_pkg::CFG_INTERPOLATED: interp_q <= cfg_wdata_i[0];
        krf_pkg::CFG_COMP_COUNT:   cc_q     <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // stage 0: accept, memory access, boundary ops
  logic               in_acc, is_elem, first, frame_end, store, bnd;
  logic [PW-1:0]      pos_q, pos_d;
  logic               sel_q;
  logic signed [31:0] inc_key_q, frame_key;
  logic [2:0]         cc_eff;
  logic [AW-1:0]      waddr, raddr, pos_a;
  krf_pkg::bt_op_t    bt_op;
  s1_tok_t            s1_q;
  logic               s1_valid_q;
  logic signed [31:0] rd_data;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_elem   = in_acc && (in_req_i.func == krf_pkg::FUNC_ELEM);
  assign first     = pos_q == '0;
  assign frame_end = in_req_i.end_of_frame || in_req_i.end_of_set;
  assign frame_key = first ? in_req_i.frame_key : inc_key_q;

  assign cc_eff = (cc_q == 3'd0) ? 3'd1 : ((cc_q > 3'd4) ? 3'd4 : cc_q);
  assign store  = (lin_q && interp_q) ? (pos_q < PW'(cc_eff))
                                      : (pos_q < PW'(FRAME_ELEMENTS));

  assign pos_a = AW'(pos_q);
  assign waddr = pos_a + (sel_q ? AW'(FRAME_ELEMENTS) : AW'(0));
  assign raddr = pos_a + (sel_q ? AW'(0) : AW'(FRAME_ELEMENTS));

  assign bt_op.clear = in_acc && (in_req_i.func == krf_pkg::FUNC_CLEAR);
  assign bt_op.add   = in_acc && (in_req_i.func == krf_pkg::FUNC_ADD);
  assign bt_op.first = is_elem && first;

  always_comb begin
    pos_d = pos_q;
    if (frame_end) pos_d = '0;
    else if (pos_q < PW'(FRAME_ELEMENTS)) pos_d = pos_q + PW'(1);
  end

  krf_boundary_table #(
    .BOUNDARY_DEPTH (BOUNDARY_DEPTH)
  ) u_bt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (bt_op),
    .key_i       (in_req_i.frame_key),
    .frame_key_i (inc_key_q),
    .match_o     (bnd)
  );

  krf_frame_mem #(
    .FRAME_ELEMENTS (FRAME_ELEMENTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (is_elem && store),
    .waddr_i (waddr),
    .wdata_i (in_req_i.sample_value),
    .re_i    (is_elem && store),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sel_q      <= 1'b0;
      inc_key_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= is_elem;
      if (is_elem) begin
        pos_q     <= pos_d;
        inc_key_q <= frame_key;
        if (frame_end) sel_q <= !sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_elem) begin
      s1_q.cmp   <= store;
      s1_q.first <= first;
      s1_q.eof   <= frame_end;
      s1_q.eos   <= in_req_i.end_of_set;
      s1_q.bnd   <= bnd;
      s1_q.key   <= frame_key;
      s1_q.val   <= in_req_i.sample_value;
    end
  end

  // stage 1: compare and decide
  logic signed [32:0] diff, mag;
  logic               exceed, diffs_now, keep_held;
  logic               held_valid_q, held_first_q, held_bnd_q, held_diff_q, inc_diff_q;
  logic signed [31:0] held_key_q;
  logic [1:0]         push_cnt;
  krf_pkg::out_res_t [1:0] push_res;
  krf_pkg::out_res_t  res_held, res_last;
  logic [FCW-1:0]     fifo_cnt;

  assign diff   = {s1_q.val[31], s1_q.val} - {rd_data[31], rd_data};
  assign mag    = diff[32] ? -diff : diff;
  assign exceed = $unsigned(mag) > {2'b00, thr_q};

  assign diffs_now = (!s1_q.first && inc_diff_q) || (s1_q.cmp && held_valid_q && exceed);
  assign keep_held = held_first_q || held_bnd_q || held_diff_q || diffs_now;

  assign res_held.decided_key = held_key_q;
  assign res_held.keep        = keep_held;
  assign res_held.run_last    = !s1_q.eos;
  assign res_last.decided_key = s1_q.key;
  assign res_last.keep        = 1'b1;
  assign res_last.run_last    = 1'b1;

  assign push_res[0] = held_valid_q ? res_held : res_last;
  assign push_res[1] = res_last;
  assign push_cnt    = (s1_valid_q && s1_q.eof)
                     ? ({1'b0, held_valid_q} + {1'b0, s1_q.eos}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      held_bnd_q   <= 1'b0;
      held_diff_q  <= 1'b0;
      inc_diff_q   <= 1'b0;
      held_key_q   <= '0;
    end else if (s1_valid_q) begin
      inc_diff_q <= diffs_now;
      if (s1_q.eof) begin
        held_first_q <= !held_valid_q;
        held_key_q   <= s1_q.key;
        held_bnd_q   <= s1_q.bnd;
        held_diff_q  <= diffs_now;
        held_valid_q <= !s1_q.eos;
      end
    end
  end

  krf_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_res_i  (push_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .count_o     (fifo_cnt)
  );

  // leave room for the worst-case results of the next request
  assign in_stall_o = (fifo_cnt + FCW'(push_cnt))
                    > FCW'(krf_pkg::RES_FIFO_DEPTH - krf_pkg::MAX_RESULTS);

  `KRF_ASSERT_IMPL(a_no_idle_stall, clk_i, rst_ni, !s1_valid_q && fifo_cnt == '0, !in_stall_o, "stall while empty")
  `KRF_ASSERT_IMPL(a_two_need_eos, clk_i, rst_ni, push_cnt == 2'd2, s1_q.eos && held_valid_q, "double result without set end")

endmodule
